>>> hw/rtl/fbpt_pkg.sv
// Shared types, codes and constants for the flash block page tracker.
package fbpt_pkg;

  // Default page count of a block and the hardware ceiling of the page map
  localparam int PAGES_DEF = 256;
  localparam int PAGE_MAX  = 256;

  // Field widths
  localparam int CFG_IW = 3;
  localparam int CFG_DW = 16;
  localparam int CNT_W  = 9;

  // Configuration register indexes
  localparam logic [CFG_IW-1:0] CFG_OWN_CHIP  = 3'd0;
  localparam logic [CFG_IW-1:0] CFG_OWN_DIE   = 3'd1;
  localparam logic [CFG_IW-1:0] CFG_OWN_PLANE = 3'd2;
  localparam logic [CFG_IW-1:0] CFG_OWN_BLOCK = 3'd3;
  localparam logic [CFG_IW-1:0] CFG_PAGES     = 3'd4;

  // Action codes
  localparam logic [2:0] ACT_ACTIVE   = 3'd0;
  localparam logic [2:0] ACT_BAD      = 3'd1;
  localparam logic [2:0] ACT_FREE     = 3'd2;
  localparam logic [2:0] ACT_RESERVED = 3'd3;
  localparam logic [2:0] ACT_UNKNOWN  = 3'd4;
  localparam logic [2:0] ACT_ADVANCE  = 3'd5;
  localparam logic [2:0] ACT_WRITE    = 3'd6;

  // Status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_ARG   = 2'd1;
  localparam logic [1:0] ST_STATE = 2'd2;

  // Block states
  localparam logic [2:0] BLK_FREE     = 3'd0;
  localparam logic [2:0] BLK_ACTIVE   = 3'd1;
  localparam logic [2:0] BLK_BAD      = 3'd2;
  localparam logic [2:0] BLK_RESERVED = 3'd3;
  localparam logic [2:0] BLK_UNKNOWN  = 3'd4;

  // Page states
  localparam logic [2:0] PG_FREE    = 3'd0;
  localparam logic [2:0] PG_VALID   = 3'd1;
  localparam logic [2:0] PG_BAD     = 3'd3;
  localparam logic [2:0] PG_UNKNOWN = 3'd4;

  typedef struct packed {
    logic [2:0]  action;
    logic [7:0]  chip_id;
    logic [3:0]  die_id;
    logic [1:0]  plane_id;
    logic [15:0] block_id;
    logic [7:0]  page_id;
    logic [2:0]  new_page_state;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [2:0]       block_state;
    logic [7:0]       next_page;
    logic             next_page_exhausted;
    logic [CNT_W-1:0] valid_page_count;
    logic [31:0]      erase_count;
  } out_item_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic cap;        // capture the input item
    logic swp_start;  // rewind the sweep address
    logic clr_we;     // reset clearing write at the sweep address
    logic cnt_rd;     // recount read at the sweep address
    logic exec;       // apply the action to the block registers
    logic fill_we;    // whole-block fill write at the sweep address
    logic upd;        // single page write at the pointer
    logic load_out;   // load the result register
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic swp_last;   // sweep address is at its last entry
    logic dirty;      // page count changed since the last recount
    logic fill;       // the action needs a whole-block fill
    logic wr;         // the action is an accepted page write
  } sts_t;

endpackage

>>> hw/rtl/fbpt_dpath.sv
// Datapath: configuration, block registers, page state memory and valid counter.
module fbpt_dpath #(
  parameter int PAGES = fbpt_pkg::PAGES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  fbpt_pkg::cmd_t              cmd,
  output fbpt_pkg::sts_t              sts,
  input  fbpt_pkg::in_item_t          in_data,
  output fbpt_pkg::out_item_t         out_data,
  input  logic                        cfg_we,
  input  logic [fbpt_pkg::CFG_IW-1:0] cfg_index,
  input  logic [fbpt_pkg::CFG_DW-1:0] cfg_data
);
  import fbpt_pkg::*;

  localparam int DEPTH = (PAGES < PAGE_MAX) ? PAGES : PAGE_MAX;
  localparam int AW    = $clog2(DEPTH);
  localparam logic [CNT_W-1:0] DEPTH_W = CNT_W'(DEPTH);

  // Configuration registers
  logic [7:0]       own_chip_r;
  logic [3:0]       own_die_r;
  logic [1:0]       own_plane_r;
  logic [15:0]      own_block_r;
  logic [CNT_W-1:0] pages_r;
  logic             dirty_r;

  // Block registers
  logic [2:0]       bs_r;
  logic [7:0]       wp_r;
  logic             exh_r;
  logic [CNT_W-1:0] count_r;
  logic [31:0]      erases_r;
  logic [1:0]       st_r;
  logic [2:0]       fv_r;

  // Item and sweep
  in_item_t         item_r;
  logic [AW-1:0]    swp_r;
  logic             cnt_pend_r;
  out_item_t        out_r;

  // Page state memory
  logic [2:0]       mem [DEPTH];
  logic [2:0]       rdata_r;

  // Decision results
  logic [CNT_W-1:0] piu_lim;
  logic [CNT_W-1:0] lim_n;
  logic [CNT_W-1:0] swp_lim;
  logic             exh_in;
  logic             exh_now;
  logic [1:0]       st_nxt;
  logic [2:0]       bs_nxt;
  logic [7:0]       wp_nxt;
  logic             exh_nxt;
  logic [31:0]      erases_nxt;
  logic             fill;
  logic [2:0]       fv_nxt;
  logic             wr;
  logic             addr_ok;
  logic             mem_we;
  logic [AW-1:0]    mem_wa;
  logic [2:0]       mem_wd;
  logic             mem_re;
  logic [AW-1:0]    mem_ra;

  // Effective page count
  assign piu_lim = (pages_r == '0) ? CNT_W'(1) : pages_r;
  assign lim_n   = (piu_lim > DEPTH_W) ? DEPTH_W : piu_lim;
  assign swp_lim = cmd.clr_we ? DEPTH_W : lim_n;
  assign exh_in  = exh_r || ({1'b0, wp_r} >= lim_n);
  assign exh_now = exh_in;

  assign addr_ok = (item_r.chip_id == own_chip_r) && (item_r.die_id == own_die_r)
                && (item_r.plane_id == own_plane_r) && (item_r.block_id == own_block_r)
                && (item_r.page_id == wp_r) && (item_r.new_page_state <= PG_UNKNOWN);

  // Decide the effect of the held action
  always_comb begin
    st_nxt     = ST_OK;
    bs_nxt     = bs_r;
    wp_nxt     = wp_r;
    exh_nxt    = exh_r;
    erases_nxt = erases_r;
    fill       = 1'b0;
    fv_nxt     = PG_FREE;
    wr         = 1'b0;
    unique case (item_r.action)
      ACT_ACTIVE: begin
        if (bs_r == BLK_BAD) begin
          st_nxt = ST_STATE;
        end else begin
          bs_nxt = BLK_ACTIVE;
          fill   = 1'b1;
          fv_nxt = PG_VALID;
        end
      end
      ACT_BAD: begin
        if (bs_r == BLK_FREE) begin
          st_nxt = ST_ARG;
        end else begin
          bs_nxt  = BLK_BAD;
          wp_nxt  = '0;
          exh_nxt = 1'b1;
          fill    = 1'b1;
          fv_nxt  = PG_BAD;
        end
      end
      ACT_FREE: begin
        if (bs_r == BLK_BAD || bs_r == BLK_FREE) begin
          st_nxt = ST_STATE;
        end else begin
          bs_nxt  = BLK_FREE;
          wp_nxt  = '0;
          exh_nxt = 1'b0;
          fill    = 1'b1;
          fv_nxt  = PG_FREE;
          if (erases_r != '1) begin
            erases_nxt = erases_r + 32'd1;
          end
        end
      end
      ACT_RESERVED: begin
        bs_nxt = BLK_RESERVED;
      end
      ACT_UNKNOWN: begin
        bs_nxt = BLK_UNKNOWN;
        fill   = 1'b1;
        fv_nxt = PG_UNKNOWN;
      end
      ACT_ADVANCE: begin
        if (exh_in || (({1'b0, wp_r} + CNT_W'(1)) >= lim_n)) begin
          wp_nxt  = '0;
          exh_nxt = 1'b1;
        end else begin
          wp_nxt = wp_r + 8'd1;
        end
      end
      ACT_WRITE: begin
        if (exh_in || !addr_ok) begin
          st_nxt = ST_ARG;
        end else begin
          wr = 1'b1;
        end
      end
      default: begin
        st_nxt = ST_ARG;
      end
    endcase
  end

  assign sts.swp_last = ((CNT_W'(swp_r) + CNT_W'(1)) == swp_lim);
  assign sts.dirty    = dirty_r;
  assign sts.fill     = fill;
  assign sts.wr       = wr;

  // Configuration writes; a new page count forces a recount
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_chip_r  <= '0;
      own_die_r   <= '0;
      own_plane_r <= '0;
      own_block_r <= '0;
      pages_r     <= CNT_W'(PAGE_MAX);
      dirty_r     <= 1'b0;
    end else begin
      if (cmd.cap) begin
        dirty_r <= 1'b0;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_OWN_CHIP:  own_chip_r  <= cfg_data[7:0];
          CFG_OWN_DIE:   own_die_r   <= cfg_data[3:0];
          CFG_OWN_PLANE: own_plane_r <= cfg_data[1:0];
          CFG_OWN_BLOCK: own_block_r <= cfg_data[15:0];
          CFG_PAGES: begin
            pages_r <= cfg_data[CNT_W-1:0];
            dirty_r <= 1'b1;
          end
          default: ;
        endcase
      end
    end
  end

  // Hold block registers, sweep address and valid count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bs_r       <= BLK_FREE;
      wp_r       <= '0;
      exh_r      <= 1'b0;
      count_r    <= '0;
      erases_r   <= '0;
      swp_r      <= '0;
      cnt_pend_r <= 1'b0;
    end else begin
      cnt_pend_r <= cmd.cnt_rd;
      if (cmd.swp_start) begin
        swp_r <= '0;
      end else if (cmd.clr_we || cmd.cnt_rd || cmd.fill_we) begin
        swp_r <= swp_r + AW'(1);
      end
      if (cmd.cap && dirty_r) begin
        count_r <= '0;
      end else if (cnt_pend_r && rdata_r == PG_VALID) begin
        count_r <= count_r + CNT_W'(1);
      end else if (cmd.exec && fill) begin
        count_r <= (fv_nxt == PG_VALID) ? lim_n : '0;
      end else if (cmd.upd) begin
        count_r <= count_r + CNT_W'(item_r.new_page_state == PG_VALID)
                           - CNT_W'(rdata_r == PG_VALID);
      end
      if (cmd.exec) begin
        bs_r     <= bs_nxt;
        wp_r     <= wp_nxt;
        exh_r    <= exh_nxt;
        erases_r <= erases_nxt;
      end
    end
  end

  // Item, status and result registers
  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      item_r <= in_data;
    end
    if (cmd.exec) begin
      st_r <= st_nxt;
      fv_r <= fv_nxt;
    end
    if (cmd.load_out) begin
      out_r.status              <= st_r;
      out_r.block_state         <= bs_r;
      out_r.next_page           <= exh_now ? 8'd0 : wp_r;
      out_r.next_page_exhausted <= exh_now;
      out_r.valid_page_count    <= count_r;
      out_r.erase_count         <= erases_r;
    end
  end

  assign out_data = out_r;

  // Page state memory port selection
  assign mem_we = cmd.clr_we || cmd.fill_we || cmd.upd;
  assign mem_wa = cmd.upd ? wp_r[AW-1:0] : swp_r;
  assign mem_wd = cmd.clr_we ? PG_FREE : (cmd.fill_we ? fv_r : item_r.new_page_state);
  assign mem_re = cmd.cnt_rd || cmd.exec;
  assign mem_ra = cmd.exec ? wp_r[AW-1:0] : swp_r;

  // Page state memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rdata_r <= mem[mem_ra];
    end
  end

endmodule

>>> hw/rtl/fbpt_ctrl.sv
// Controller: sequences clearing, recount, action, fill, page update and result transfer.
module fbpt_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  output logic           out_valid,
  input  logic           out_stall,
  input  fbpt_pkg::sts_t sts,
  output fbpt_pkg::cmd_t cmd
);
  import fbpt_pkg::*;

  typedef enum logic [2:0] {
    S_CLR,
    S_IDLE,
    S_CNT,
    S_CWAIT,
    S_EXEC,
    S_FILL,
    S_UPD,
    S_FIN
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;
  logic   slot_free;

  assign slot_free = !out_valid_r || !out_stall;

  // Decode commands and next state
  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_CLR: begin
        cmd.clr_we = 1'b1;
        if (sts.swp_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.cap       = 1'b1;
          cmd.swp_start = 1'b1;
          state_nxt     = sts.dirty ? S_CNT : S_EXEC;
        end
      end
      S_CNT: begin
        cmd.cnt_rd = 1'b1;
        if (sts.swp_last) begin
          state_nxt = S_CWAIT;
        end
      end
      S_CWAIT: begin
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        cmd.exec      = 1'b1;
        cmd.swp_start = 1'b1;
        if (sts.fill) begin
          state_nxt = S_FILL;
        end else if (sts.wr) begin
          state_nxt = S_UPD;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_FILL: begin
        cmd.fill_we = 1'b1;
        if (sts.swp_last) begin
          state_nxt = S_FIN;
        end
      end
      S_UPD: begin
        cmd.upd   = 1'b1;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (slot_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLR;
      end
    endcase
  end

  // Set the result flag on load, drop it on transfer
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Hold state and result flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

>>> hw/rtl/flash_block_page_tracker.sv
// Top level: bookkeeping of one flash block with a page state map.
//
//  channel  | handshake              | payload
//  ---------+------------------------+------------------------------
//  in_      | in_valid / in_stall    | in_data  (fbpt_pkg::in_item_t)
//  out_     | out_valid / out_stall  | out_data (fbpt_pkg::out_item_t)
//  cfg_     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// An item passes through capture, execute and result load; whole-block marks
// (active, bad, free, unknown) add a fill pass over the page memory, one entry a
// cycle, a page write adds an update of the page whose old state execute read, and
// the first item after a pages_in_use write adds a recount of the valid pages.
// After reset a clearing pass writes min(PAGES,256) entries, one a cycle,
// while in_stall stays high; configuration writes are taken throughout.
// A result waiting under out_stall does not block the next item until that
// item's own result is ready to load.
module flash_block_page_tracker #(
  parameter int PAGES = fbpt_pkg::PAGES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  fbpt_pkg::in_item_t          in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output fbpt_pkg::out_item_t         out_data,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [fbpt_pkg::CFG_IW-1:0] cfg_index,
  input  logic [fbpt_pkg::CFG_DW-1:0] cfg_data
);
  import fbpt_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic cfg_we;

  // Take configuration at any time
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  fbpt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  fbpt_dpath #(
    .PAGES (PAGES)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // One item in flight: a transfer closes the input until the item is done
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while an item is in flight");

  // An exhausted pointer always reads as page zero
  a_exh_page_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!out_data.next_page_exhausted || out_data.next_page == 8'd0))
    else $error("exhausted pointer with nonzero page");

  // The valid page count never exceeds the page map
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.valid_page_count <= CNT_W'(PAGE_MAX)))
    else $error("valid page count out of range");

  // A result is loaded only after an accepted item
  a_load_after_item: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> in_stall)
    else $error("result loaded while idle");

endmodule
